// ----- rtl/rgba_layer_blend_unit_assert.svh -----
// Assertion macros for the layer blend unit.
`ifndef RGBA_LAYER_BLEND_UNIT_ASSERT_SVH
`define RGBA_LAYER_BLEND_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RLB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define RLB_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define RLB_ASSERT(label, prop, msg)
`define RLB_ASSERT_RST(label, prop, msg)
`endif
`endif

// ----- rtl/rlb_pkg.sv -----
// Types, constants and arithmetic helpers for the layer blend unit.
package rlb_pkg;

   localparam int PIPE_DEPTH = 6;

   typedef struct packed {
      logic [7:0] bottom_red;
      logic [7:0] bottom_green;
      logic [7:0] bottom_blue;
      logic [7:0] bottom_alpha;
      logic [7:0] top_red;
      logic [7:0] top_green;
      logic [7:0] top_blue;
      logic [7:0] top_alpha;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
   } rsp_type;

   typedef enum logic [4:0] {
      MODE_NORMAL   = 5'd0,
      MODE_MULTIPLY = 5'd1,
      MODE_SCREEN   = 5'd2,
      MODE_OVERLAY  = 5'd3,
      MODE_HARDLT   = 5'd4,
      MODE_PEGTOP   = 5'd5,
      MODE_DODGE    = 5'd6,
      MODE_LINDODGE = 5'd7,
      MODE_DIVIDE   = 5'd8,
      MODE_BURN     = 5'd9,
      MODE_LINBURN  = 5'd10,
      MODE_VIVID    = 5'd11,
      MODE_LINLIGHT = 5'd12,
      MODE_SUB      = 5'd13,
      MODE_ADD      = 5'd14,
      MODE_DIFF     = 5'd15,
      MODE_DARKEN   = 5'd16,
      MODE_LIGHTEN  = 5'd17,
      MODE_AVERAGE  = 5'd18
   } mode_type;

   // Which datapath produces the final byte.
   typedef enum logic [1:0] {
      CLS_SIMPLE = 2'd0,
      CLS_PROD   = 2'd1,
      CLS_PEG    = 2'd2,
      CLS_DIV    = 2'd3
   } cls_type;

   typedef struct packed {
      cls_type     cls;
      logic        inv;
      logic        dbl;
      logic [7:0]  b;
      logic [7:0]  simple;
      logic [23:0] val;
      logic [15:0] dn;
      logic [7:0]  dy;
      logic        dz;
      logic        dsat;
      logic [7:0]  rem;
      logic [7:0]  q;
   } lane_stage_type;

   // One restoring division step: {quotient bit, new remainder}.
   function automatic logic [8:0] div_step(input logic [7:0] rem, input logic nbit,
                                           input logic [7:0] dvs);
      logic [8:0] s;
      logic [8:0] d;
      logic [8:0] res;
      s = {rem, nbit};
      d = s - {1'b0, dvs};
      if (s >= {1'b0, dvs}) begin
         res = {1'b1, d[7:0]};
      end else begin
         res = {1'b0, s[7:0]};
      end
      return res;
   endfunction

   // floor(x / 255) for x below 2^24 / 1.004; estimate is low by at most one.
   function automatic logic [15:0] div_by_255(input logic [23:0] x);
      logic [24:0] sum;
      logic [15:0] q0;
      logic [23:0] r;
      sum = {1'b0, x} + {9'b0, x[23:8]} + {17'b0, x[23:16]};
      q0 = sum[23:8];
      r = x - ({q0, 8'b0} - {8'b0, q0});
      if (r >= 24'd255) begin
         q0 = q0 + 16'd1;
      end
      return q0;
   endfunction

endpackage

// ----- rtl/rlb_lane.sv -----
// One color channel of the blend pipeline: operand setup, products, divider.
module rlb_lane (
   input  logic                                clock,
   input  rlb_pkg::mode_type                   mode,
   input  logic                                bright,
   input  logic [7:0]                          bot,
   input  logic [7:0]                          top,
   input  logic [rlb_pkg::PIPE_DEPTH-1:0]      load,
   output logic [7:0]                          res
);

   rlb_pkg::lane_stage_type stg_ff [1:rlb_pkg::PIPE_DEPTH-1];
   rlb_pkg::lane_stage_type stg_in [1:rlb_pkg::PIPE_DEPTH-1];
   rlb_pkg::lane_stage_type stg1_in;
   logic [7:0] res_ff;
   logic [7:0] res_in;

   // Stage 1: decode mode, pick multiplier and divider operands.
   always_comb begin
      rlb_pkg::mode_type eff;
      logic [7:0]  ma;
      logic [7:0]  mb;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [8:0]  sum9;
      logic [8:0]  lb9;
      logic [15:0] prod;
      logic [15:0] dn;
      eff = mode;
      if (mode == rlb_pkg::MODE_VIVID) begin
         eff = bright ? rlb_pkg::MODE_DODGE : rlb_pkg::MODE_BURN;
      end else if (mode == rlb_pkg::MODE_LINLIGHT) begin
         eff = bright ? rlb_pkg::MODE_ADD : rlb_pkg::MODE_LINBURN;
      end
      stg1_in = '0;
      stg1_in.cls = rlb_pkg::CLS_SIMPLE;
      stg1_in.b = bot;
      stg1_in.simple = top;
      ma = bot;
      mb = top;
      x = bot;
      y = top;
      sum9 = {1'b0, bot} + {1'b0, top};
      lb9 = sum9 - 9'd255;
      unique case (eff)
         rlb_pkg::MODE_MULTIPLY: begin
            stg1_in.cls = rlb_pkg::CLS_PROD;
         end
         rlb_pkg::MODE_SCREEN: begin
            stg1_in.cls = rlb_pkg::CLS_PROD;
            stg1_in.inv = 1'b1;
            ma = ~bot;
            mb = ~top;
         end
         rlb_pkg::MODE_OVERLAY, rlb_pkg::MODE_HARDLT: begin
            stg1_in.cls = rlb_pkg::CLS_PROD;
            stg1_in.dbl = 1'b1;
            // dark side multiplies, light side screens
            if ((eff == rlb_pkg::MODE_OVERLAY) ? bot[7] : top[7]) begin
               stg1_in.inv = 1'b1;
               ma = ~bot;
               mb = ~top;
            end
         end
         rlb_pkg::MODE_PEGTOP: begin
            stg1_in.cls = rlb_pkg::CLS_PEG;
            ma = top;
            mb = ~bot;
         end
         rlb_pkg::MODE_DODGE: begin
            stg1_in.cls = rlb_pkg::CLS_DIV;
            y = ~top;
         end
         rlb_pkg::MODE_DIVIDE: begin
            stg1_in.cls = rlb_pkg::CLS_DIV;
         end
         rlb_pkg::MODE_BURN: begin
            stg1_in.cls = rlb_pkg::CLS_DIV;
            stg1_in.inv = 1'b1;
            x = ~bot;
         end
         rlb_pkg::MODE_LINDODGE, rlb_pkg::MODE_ADD: begin
            stg1_in.simple = sum9[8] ? 8'd255 : sum9[7:0];
         end
         rlb_pkg::MODE_LINBURN: begin
            stg1_in.simple = (sum9 > 9'd255) ? lb9[7:0] : 8'd0;
         end
         rlb_pkg::MODE_SUB: begin
            stg1_in.simple = (bot > top) ? (bot - top) : 8'd0;
         end
         rlb_pkg::MODE_DIFF: begin
            stg1_in.simple = (bot > top) ? (bot - top) : (top - bot);
         end
         rlb_pkg::MODE_DARKEN: begin
            stg1_in.simple = (bot < top) ? bot : top;
         end
         rlb_pkg::MODE_LIGHTEN: begin
            stg1_in.simple = (bot > top) ? bot : top;
         end
         rlb_pkg::MODE_AVERAGE: begin
            stg1_in.simple = sum9[8:1];
         end
         default: begin
         end
      endcase
      prod = ma * mb;
      dn = {x, 8'b0} - {8'b0, x};
      stg1_in.val = {8'b0, prod};
      stg1_in.dn = dn;
      stg1_in.dy = y;
      stg1_in.dz = (y == 8'd0);
      stg1_in.dsat = (dn >= {y, 8'b0});
      stg1_in.rem = dn[15:8];
   end

   // Stages 2..5: two quotient bits each, plus the product / divide-by-255 chain.
   always_comb begin
      rlb_pkg::lane_stage_type cur;
      logic [7:0]  sh;
      logic [8:0]  st1;
      logic [8:0]  st2;
      logic [15:0] pk;
      logic [16:0] n17;
      logic [24:0] prd;
      stg_in[1] = stg1_in;
      for (int k = 1; k < rlb_pkg::PIPE_DEPTH - 1; k++) begin
         cur = stg_ff[k];
         stg_in[k+1] = cur;
         sh = cur.dn[7:0] << (2 * (k - 1));
         st1 = rlb_pkg::div_step(cur.rem, sh[7], cur.dy);
         st2 = rlb_pkg::div_step(st1[7:0], sh[6], cur.dy);
         stg_in[k+1].rem = st2[7:0];
         stg_in[k+1].q = {cur.q[5:0], st1[8], st2[8]};
         pk = {cur.b, 8'b0} - {8'b0, cur.b};
         n17 = {1'b0, pk} + {cur.val[15:0], 1'b0};
         prd = cur.b * cur.val[16:0];
         if (k == 1) begin
            if (cur.cls == rlb_pkg::CLS_PEG) begin
               stg_in[k+1].val = {7'b0, n17};
            end else if (cur.dbl) begin
               stg_in[k+1].val = {7'b0, cur.val[15:0], 1'b0};
            end
         end else if (k == 2) begin
            if (cur.cls == rlb_pkg::CLS_PEG) begin
               stg_in[k+1].val = prd[23:0];
            end else begin
               stg_in[k+1].val = {8'b0, rlb_pkg::div_by_255(cur.val)};
            end
         end else if (cur.cls == rlb_pkg::CLS_PEG) begin
            stg_in[k+1].val = {8'b0, rlb_pkg::div_by_255(cur.val)};
         end
      end
   end

   always_comb begin
      rlb_pkg::lane_stage_type cur;
      logic [7:0] r;
      cur = stg_ff[rlb_pkg::PIPE_DEPTH-1];
      unique case (cur.cls)
         rlb_pkg::CLS_SIMPLE: r = cur.simple;
         rlb_pkg::CLS_DIV:    r = (cur.dz || cur.dsat) ? 8'd255 : cur.q;
         default:             r = cur.val[7:0];
      endcase
      res_in = cur.inv ? ~r : r;
   end

   always_ff @(posedge clock) begin
      for (int k = 1; k < rlb_pkg::PIPE_DEPTH; k++) begin
         if (load[k-1]) begin
            stg_ff[k] <= stg_in[k];
         end
      end
      if (load[rlb_pkg::PIPE_DEPTH-1]) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

// ----- rtl/rgba_layer_blend_unit.sv -----
// Throughput: one pixel per cycle while rsp_stall is low; the product chain, divide-by-255 steps and the
// two-bits-per-stage quotient divider are all pipelined across the six stages.
// Stall: each stage fills whenever it is empty, so bubbles collapse under rsp_stall.
// Reset (synchronous, active high) clears the stage valid bits and the blend mode.
// No clearing pass: the unit accepts a transaction in the first cycle after reset.
`include "rgba_layer_blend_unit_assert.svh"
module rgba_layer_blend_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rlb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rlb_pkg::rsp_type rsp_data,
   input  logic             csr_write_enable,
   input  logic [4:0]       csr_write_data
);

   localparam int LAST = rlb_pkg::PIPE_DEPTH - 1;

   rlb_pkg::mode_type mode_ff;
   logic [LAST:0] valid_ff;
   logic [LAST:0] valid_in;
   logic [LAST:0] load;
   logic [9:0]    lum_sum;
   logic          bright;

   always_comb begin
      load[LAST] = !valid_ff[LAST] || !rsp_stall;
      for (int i = LAST - 1; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
      valid_in = valid_ff;
      if (load[0]) begin
         valid_in[0] = req_valid;
      end
      for (int i = 1; i <= LAST; i++) begin
         if (load[i]) begin
            valid_in[i] = valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         mode_ff <= rlb_pkg::MODE_NORMAL;
      end else begin
         valid_ff <= valid_in;
         if (csr_write_enable) begin
            mode_ff <= rlb_pkg::mode_type'(csr_write_data);
         end
      end
   end

   // (r+g+b)/3 >= 128 is the same as r+g+b >= 384
   assign lum_sum = {2'b0, req_data.top_red} + {2'b0, req_data.top_green}
                  + {2'b0, req_data.top_blue};
   assign bright = (lum_sum >= 10'd384);

   rlb_lane u_lane_red (
      .clock(clock), .mode(mode_ff), .bright(bright),
      .bot(req_data.bottom_red), .top(req_data.top_red),
      .load(load), .res(rsp_data.out_red)
   );

   rlb_lane u_lane_green (
      .clock(clock), .mode(mode_ff), .bright(bright),
      .bot(req_data.bottom_green), .top(req_data.top_green),
      .load(load), .res(rsp_data.out_green)
   );

   rlb_lane u_lane_blue (
      .clock(clock), .mode(mode_ff), .bright(bright),
      .bot(req_data.bottom_blue), .top(req_data.top_blue),
      .load(load), .res(rsp_data.out_blue)
   );

   rlb_lane u_lane_alpha (
      .clock(clock), .mode(mode_ff), .bright(bright),
      .bot(req_data.bottom_alpha), .top(req_data.top_alpha),
      .load(load), .res(rsp_data.out_alpha)
   );

   assign req_stall = !load[0];
   assign rsp_valid = valid_ff[LAST];

   `RLB_ASSERT(a_stall_only_when_full, req_stall |-> (&valid_ff), "input stalled with a free stage")
   `RLB_ASSERT(a_no_stall_when_drained, !rsp_stall |-> !req_stall, "input stalled while output drains")
   `RLB_ASSERT_RST(a_mode_write, (!reset && csr_write_enable) |=> (mode_ff == $past(csr_write_data)), "mode register write lost")

endmodule

// ----- dv/tb.sv -----
// Testbench for the RGBA layer blend unit: per-mode directed and random pixel checks.
`timescale 1ns / 1ps
module tb;

   localparam int MAX_ERR_PRINT = 10;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = rlb_pkg::PIPE_DEPTH + 4;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   rlb_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rlb_pkg::rsp_type rsp_data;
   logic    csr_write_enable = 1'b0;
   logic [4:0] csr_write_data = '0;

   logic [4:0] mode_shadow;
   rlb_pkg::rsp_type pending_pixels[$];
   int         error_count = 0;
   int         idle_cycles = 0;
   int         rsp_wait = 0;
   bit         rsp_idle_en = 1'b1;

   rgba_layer_blend_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // saturating ratio x*255/y, 255 on zero divisor
   function automatic int sat_ratio(int x, int y);
      int q;
      if (y == 0) return 255;
      q = (x * 255) / y;
      return (q > 255) ? 255 : q;
   endfunction

   function automatic int overlay_mix(int b, int t);
      if (b < 128) return (2 * b * t) / 255;
      return 255 - (2 * (255 - b) * (255 - t)) / 255;
   endfunction

   function automatic int blend_channel(logic [4:0] m, int b, int t, bit bright);
      int sum;
      sum = b + t;
      case (m)
         rlb_pkg::MODE_MULTIPLY: return (b * t) / 255;
         rlb_pkg::MODE_SCREEN:   return 255 - ((255 - b) * (255 - t)) / 255;
         rlb_pkg::MODE_OVERLAY:  return overlay_mix(b, t);
         rlb_pkg::MODE_HARDLT:   return overlay_mix(t, b);
         rlb_pkg::MODE_PEGTOP:   return (b * (255 * b + 2 * t * (255 - b))) / 65025;
         rlb_pkg::MODE_DODGE:    return sat_ratio(b, 255 - t);
         rlb_pkg::MODE_LINDODGE, rlb_pkg::MODE_ADD: return (sum > 255) ? 255 : sum;
         rlb_pkg::MODE_DIVIDE:   return sat_ratio(b, t);
         rlb_pkg::MODE_BURN:     return 255 - sat_ratio(255 - b, t);
         rlb_pkg::MODE_LINBURN:  return (sum > 255) ? sum - 255 : 0;
         rlb_pkg::MODE_VIVID:
            return bright ? sat_ratio(b, 255 - t) : 255 - sat_ratio(255 - b, t);
         rlb_pkg::MODE_LINLIGHT: return bright ? ((sum > 255) ? 255 : sum)
                                               : ((sum > 255) ? sum - 255 : 0);
         rlb_pkg::MODE_SUB:      return (b > t) ? b - t : 0;
         rlb_pkg::MODE_DIFF:     return (b > t) ? b - t : t - b;
         rlb_pkg::MODE_DARKEN:   return (b < t) ? b : t;
         rlb_pkg::MODE_LIGHTEN:  return (b > t) ? b : t;
         rlb_pkg::MODE_AVERAGE:  return sum / 2;
         default:                return t;
      endcase
   endfunction

   function automatic rlb_pkg::rsp_type blend_pixel(rlb_pkg::req_type p);
      rlb_pkg::rsp_type r;
      bit bright;
      bright = ((int'(p.top_red) + int'(p.top_green) + int'(p.top_blue)) / 3) >= 128;
      r.out_red   = 8'(blend_channel(mode_shadow, int'(p.bottom_red),
                                     int'(p.top_red), bright));
      r.out_green = 8'(blend_channel(mode_shadow, int'(p.bottom_green),
                                     int'(p.top_green), bright));
      r.out_blue  = 8'(blend_channel(mode_shadow, int'(p.bottom_blue),
                                     int'(p.top_blue), bright));
      r.out_alpha = 8'(blend_channel(mode_shadow, int'(p.bottom_alpha),
                                     int'(p.top_alpha), bright));
      return r;
   endfunction

   // valid stays high into the next transaction when there is no gap
   task automatic send_pixel(rlb_pkg::req_type p);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_pixels.push_back(blend_pixel(p));
   endtask

   // drains the unit before writing the mode register
   task automatic set_mode(logic [4:0] m);
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= m;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      mode_shadow = m;
   endtask

   function automatic rlb_pkg::req_type random_pixel();
      rlb_pkg::req_type p;
      p = {$urandom, $urandom};
      // bias toward channel extremes
      if ($urandom_range(0, 5) == 0) p.top_red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      if ($urandom_range(0, 5) == 0) p.top_green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      if ($urandom_range(0, 5) == 0) p.bottom_red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      if ($urandom_range(0, 5) == 0) p.top_alpha = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return p;
   endfunction

   // rsp side: after each transaction, stall a random number of cycles if rsp_idle_en
   always @(posedge clock) begin
      rlb_pkg::rsp_type want;
      int w;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_pixels.size() == 0) begin
               error_count++;
               if (error_count <= MAX_ERR_PRINT)
                  $display("unexpected pixel %h", rsp_data);
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_data !== want) begin
                  error_count++;
                  if (error_count <= MAX_ERR_PRINT)
                     $display("mode %0d: exp %h got %h (r %h/%h g %h/%h b %h/%h a %h/%h)",
                        mode_shadow, want, rsp_data, want.out_red, rsp_data.out_red,
                        want.out_green, rsp_data.out_green, want.out_blue,
                        rsp_data.out_blue, want.out_alpha, rsp_data.out_alpha);
               end
            end
            w = rsp_idle_en ? $urandom_range(0, 12) : 0;
            rsp_wait  <= w;
            rsp_stall <= (w > 0);
         end else if (rsp_wait > 0) begin
            rsp_wait  <= rsp_wait - 1;
            rsp_stall <= (rsp_wait > 1);
         end
      end
   end

   // watchdog on cycles with no transaction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic test_directed_modes();
      rlb_pkg::req_type p;
      logic [4:0] m;
      for (int i = 0; i <= 19; i++) begin
         m = (i == 19) ? 5'd31 : 5'(i);
         set_mode(m);
         p = '0; send_pixel(p);
         p = '1; send_pixel(p);
         // zero divisor cases: top 0 and top 255 with bottom 0
         p = {8'd0, 8'd0, 8'd200, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
         send_pixel(p);
         // brightness threshold: 128 and 127 averages
         p = {8'd90, 8'd160, 8'd20, 8'd127, 8'd128, 8'd128, 8'd128, 8'd60};
         send_pixel(p);
         p = {8'd90, 8'd160, 8'd20, 8'd127, 8'd127, 8'd128, 8'd128, 8'd200};
         send_pixel(p);
      end
   endtask

   task automatic test_random_pixels();
      for (int k = 0; k < 10; k++) begin
         case (k)
            0: set_mode(rlb_pkg::MODE_NORMAL);
            1: set_mode(rlb_pkg::MODE_AVERAGE);
            2: set_mode(5'd31);
            default: set_mode(5'($urandom_range(0, 18)));
         endcase
         rsp_idle_en = (k % 3) != 2;
         repeat (30) send_pixel(random_pixel());
      end
      rsp_idle_en = 1'b1;
   endtask

   initial begin
      mode_shadow = rlb_pkg::MODE_NORMAL;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_modes();
      test_random_pixels();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/rlb_pkg.sv
rtl/rlb_lane.sv
rtl/rgba_layer_blend_unit.sv
dv/tb.sv
